[hw/rtl/tako_pkg.sv]
// Package for the two-axis scalar Kalman odometry block.
// Types, fixed-point constants and register indexes; no dependencies.
package tako_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned TimeWidth  = 48;
  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned GainWidth  = FracBits + 1;
  localparam int unsigned UsPerS     = 1000000;
  localparam int unsigned MagWidth   = ValueWidth + 1;
  localparam int unsigned ProdWidth  = MagWidth + 20;
  localparam logic [ValueWidth-1:0] QReset = 32'd262144;
  localparam logic [ValueWidth-1:0] RReset = 32'd262144;

  typedef enum logic [AddrWidth-1:0] {
    RegProcessNoise     = 3'd0,
    RegMeasurementNoise = 3'd4
  } reg_addr_e;

  typedef enum logic [2:0] {
    StIdle, StKalman, StVelStart, StVel, StOut
  } state_e;

  typedef struct packed {
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] altitude;
    logic [47:0]        time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_x;
    logic signed [31:0] filtered_y;
    logic signed [31:0] altitude_out;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               dt_zero;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lane_ctl_t;

  function automatic logic signed [ValueWidth-1:0] sat_val(input logic signed [ValueWidth+1:0] v);
    logic signed [ValueWidth+1:0] hi;
    logic signed [ValueWidth+1:0] lo;
    hi = (ValueWidth+2)'({1'b0, {(ValueWidth-1){1'b1}}});
    lo = -hi - (ValueWidth+2)'(1);
    if (v > hi) return hi[ValueWidth-1:0];
    else if (v < lo) return lo[ValueWidth-1:0];
    else return v[ValueWidth-1:0];
  endfunction

endpackage

[hw/rtl/tako_kalman_lane.sv]
// One scalar Kalman lane: variance update, iterative gain divider, estimate update.
// Depends on tako_pkg.
module tako_kalman_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  init_i,
  input  logic signed [tako_pkg::ValueWidth-1:0] meas_i,
  input  logic [tako_pkg::ValueWidth-1:0]       q_i,
  input  logic [tako_pkg::ValueWidth-1:0]       r_i,
  output logic signed [tako_pkg::ValueWidth-1:0] est_o,
  output tako_pkg::lane_ctl_t                   ctl_o
);
  import tako_pkg::*;

  localparam int unsigned CntW = $clog2(FracBits + 4);

  logic signed [ValueWidth-1:0] est_q, est_d;
  logic [ValueWidth-1:0] var_q, var_d;
  logic [ValueWidth-1:0] p_q, p_d;
  logic [ValueWidth:0]   den_q, den_d;
  logic [ValueWidth+1:0] rem_q, rem_d;
  logic [GainWidth-1:0]  gain_q, gain_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic signed [ValueWidth-1:0] meas_q, meas_d;

  logic [ValueWidth:0]   psum;
  logic [ValueWidth+1:0] rsh;
  logic signed [ValueWidth:0] innov;
  logic [ValueWidth:0]   mag;
  logic [ValueWidth+GainWidth:0] prod;
  logic [ValueWidth+GainWidth:0] vprod;
  logic [GainWidth-1:0]  ginv;

  always_comb begin
    psum   = {1'b0, var_q} + {1'b0, q_i};
    rsh    = {rem_q[ValueWidth:0], 1'b0};
    innov  = {meas_q[ValueWidth-1], meas_q} - {est_q[ValueWidth-1], est_q};
    mag    = innov[ValueWidth] ? (ValueWidth+1)'(-innov) : (ValueWidth+1)'(innov);
    prod   = (ValueWidth+GainWidth+1)'(mag) * (ValueWidth+GainWidth+1)'(gain_q);
    ginv   = GainWidth'(1 << FracBits) - gain_q;
    vprod  = (ValueWidth+GainWidth+1)'(p_q) * (ValueWidth+GainWidth+1)'(ginv);
    est_d  = est_q; var_d = var_q; p_d = p_q; den_d = den_q; rem_d = rem_q;
    gain_d = gain_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0; meas_d = meas_q;
    if (init_i) begin
      est_d = '0; var_d = '0;
    end else if (start_i) begin
      p_d    = psum[ValueWidth] ? '1 : psum[ValueWidth-1:0];
      meas_d = meas_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == '0) begin
        den_d  = {1'b0, p_q} + {1'b0, r_i};
        rem_d  = {2'b0, p_q};
        gain_d = '0;
      end else if (cnt_q == CntW'(1)) begin
        if (den_q == '0) cnt_d = CntW'(FracBits + 2);
        else if (rem_q >= {1'b0, den_q}) begin
          gain_d = GainWidth'(1); rem_d = rem_q - {1'b0, den_q};
        end
      end else if (cnt_q <= CntW'(FracBits + 1)) begin
        if (rsh >= {1'b0, den_q}) begin
          rem_d = rsh - {1'b0, den_q}; gain_d = {gain_q[GainWidth-2:0], 1'b1};
        end else begin
          rem_d = rsh; gain_d = {gain_q[GainWidth-2:0], 1'b0};
        end
      end else begin
        est_d  = sat_val(innov[ValueWidth]
          ? (ValueWidth+2)'(est_q) - (ValueWidth+2)'(prod[ValueWidth+FracBits:FracBits])
          : (ValueWidth+2)'(est_q) + (ValueWidth+2)'(prod[ValueWidth+FracBits:FracBits]));
        var_d  = vprod[ValueWidth+FracBits-1:FracBits];
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0; var_q <= '0; busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      est_q <= est_d; var_q <= var_d; busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; den_q <= den_d; rem_q <= rem_d; gain_q <= gain_d; meas_q <= meas_d;
  end

  assign est_o = est_q;
  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};

  gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> gain_q <= GainWidth'(1 << FracBits)) else $error("gain above one");
  no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("lane restarted while busy");
  done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
endmodule

[hw/rtl/tako_vel_div.sv]
// Velocity unit: |delta|*1e6/dt by restoring division, sign and saturation.
// Depends on tako_pkg.
module tako_vel_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [tako_pkg::ValueWidth:0]   delta_i,
  input  logic                                   neg_i,
  input  logic [tako_pkg::TimeWidth-1:0]         dt_i,
  output logic signed [tako_pkg::ValueWidth-1:0] vel_o,
  output logic                                   done_o
);
  import tako_pkg::*;

  localparam int unsigned NumW = ProdWidth;
  localparam int unsigned CntW = $clog2(NumW + 2);

  logic [NumW-1:0]      num_q, num_d;
  logic [TimeWidth:0]   rem_q, rem_d;
  logic [TimeWidth-1:0] dt_q, dt_d;
  logic                 neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic signed [ValueWidth-1:0] vel_q, vel_d;
  logic [ValueWidth:0]  mag;
  logic [TimeWidth:0]   rsh;
  logic [NumW-1:0]      lim;

  always_comb begin
    mag   = delta_i[ValueWidth] ? (ValueWidth+1)'(-delta_i) : (ValueWidth+1)'(delta_i);
    rsh   = {rem_q[TimeWidth-1:0], num_q[NumW-1]};
    lim   = neg_q ? NumW'((ValueWidth+1)'(1) << (ValueWidth-1))
                  : NumW'(((ValueWidth+1)'(1) << (ValueWidth-1)) - (ValueWidth+1)'(1));
    num_d = num_q; rem_d = rem_q; dt_d = dt_q; neg_d = neg_q; busy_d = busy_q;
    cnt_d = cnt_q; vel_d = vel_q; done_d = 1'b0;
    if (start_i) begin
      num_d  = NumW'(mag) * NumW'(UsPerS);
      rem_d  = '0; dt_d = dt_i; cnt_d = '0; busy_d = 1'b1;
      neg_d  = delta_i[ValueWidth] ^ neg_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q < CntW'(NumW)) begin
        if (rsh >= {1'b0, dt_q}) begin
          rem_d = rsh - {1'b0, dt_q}; num_d = {num_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = rsh; num_d = {num_q[NumW-2:0], 1'b0};
        end
      end else begin
        if (num_q > lim) num_d = lim;
        vel_d  = neg_q ? ValueWidth'(-num_d) : ValueWidth'(num_d);
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; dt_q <= dt_d; neg_q <= neg_d; vel_q <= vel_d;
  end

  assign vel_o  = vel_q;
  assign done_o = done_q;

  rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && dt_q != '0 |-> rem_q < {1'b0, dt_q}) else $error("remainder too large");
  done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("velocity unit restarted");
endmodule

[hw/rtl/two_axis_scalar_kalman_odometry.sv]
// Two-axis scalar Kalman odometry, top level: register port, sequencer,
// two Kalman lanes and three velocity lanes merged into one output register.
// Depends on tako_pkg, tako_kalman_lane, tako_vel_div.
//
// Input items transfer on in_valid_i/in_ready_o, results on out_valid_o/out_ready_i.
// The first item after reset sets the origin and gives no result; each later
// item gives one result.
// Each item runs through the Kalman lanes (a 17-step gain divider, then a
// handoff) and then the velocity lanes (a 53-bit restoring divider, start
// and output load) before out_valid_o rises. One item is in work at a time,
// so the next item waits for both serial dividers to finish.
// A result waits in the output register while the receiver stalls; the next
// input is taken only once the previous result has transferred.
// Reset clears the filter state and sets both noise registers to 4.0.
// Registers: process_noise at 0x0, measurement_noise at 0x4, written over APB.
module two_axis_scalar_kalman_odometry (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tako_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tako_pkg::out_item_t   out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [tako_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tako_pkg::*;

  state_e state_q, state_d;
  logic [ValueWidth-1:0] q_q, r_q;
  logic started_q;
  logic signed [ValueWidth-1:0] org_x_q, org_y_q, prev_alt_q, old_x_q, old_y_q, alt_q;
  logic signed [ValueWidth-1:0] rel_x_q, rel_y_q, alt_old_q;
  logic [TimeWidth-1:0] prev_t_q, dt_q;
  logic out_valid_q;
  out_item_t out_q;

  logic accept, wr, k_start, k_init, v_start, out_load;
  logic signed [ValueWidth-1:0] est_x, est_y, vx, vy, vz;
  lane_ctl_t ctl_x, ctl_y;
  logic vdx, vdy, vdz, kdone_x_q, kdone_y_q;
  logic signed [ValueWidth-1:0] relx, rely;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    case (paddr)
      RegProcessNoise:     prdata = q_q;
      RegMeasurementNoise: prdata = r_q;
      default:             prdata = '0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign relx = sat_val((ValueWidth+2)'(in_data_i.meas_x) - (ValueWidth+2)'(org_x_q));
  assign rely = sat_val((ValueWidth+2)'(in_data_i.meas_y) - (ValueWidth+2)'(org_y_q));
  assign k_init = accept && !started_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (accept && started_q) state_d = StKalman;
      StKalman:   if (kdone_x_q && kdone_y_q) state_d = StVelStart;
      StVelStart: state_d = StVel;
      StVel:      if (vdx) state_d = StOut;
      StOut:      if (out_ready_i) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0; k_start = 1'b0; v_start = 1'b0; out_load = 1'b0;
    case (state_q)
      StIdle:     begin in_ready_o = 1'b1; k_start = in_valid_i && started_q; end
      StVelStart: v_start = dt_q != '0;
      StVel:      out_load = vdx;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; q_q <= QReset; r_q <= RReset; started_q <= 1'b0;
      org_x_q <= '0; org_y_q <= '0; prev_alt_q <= '0; prev_t_q <= '0;
      out_valid_q <= 1'b0; kdone_x_q <= 1'b0; kdone_y_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr && paddr == RegProcessNoise) q_q <= pwdata;
      if (wr && paddr == RegMeasurementNoise) r_q <= pwdata;
      if (accept) begin
        started_q <= 1'b1; prev_alt_q <= in_data_i.altitude; prev_t_q <= in_data_i.time_us;
        if (!started_q) begin
          org_x_q <= in_data_i.meas_x; org_y_q <= in_data_i.meas_y;
        end
      end
      if (k_start) begin kdone_x_q <= 1'b0; kdone_y_q <= 1'b0; end
      else begin
        if (ctl_x.done) kdone_x_q <= 1'b1;
        if (ctl_y.done) kdone_y_q <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_x_q <= est_x; old_y_q <= est_y; alt_q <= in_data_i.altitude;
      alt_old_q <= prev_alt_q; dt_q <= in_data_i.time_us - prev_t_q;
      rel_x_q <= relx; rel_y_q <= rely;
    end
    if (out_load) begin
      out_q.filtered_x <= est_x; out_q.filtered_y <= est_y; out_q.altitude_out <= alt_q;
      out_q.vel_x <= (dt_q == '0) ? '0 : vx;
      out_q.vel_y <= (dt_q == '0) ? '0 : vy;
      out_q.vel_z <= (dt_q == '0) ? '0 : vz;
      out_q.dt_zero <= dt_q == '0;
    end
  end

  tako_kalman_lane u_lane_x (.clk_i, .rst_ni, .start_i(k_start), .init_i(k_init),
    .meas_i(relx), .q_i(q_q), .r_i(r_q), .est_o(est_x), .ctl_o(ctl_x));
  tako_kalman_lane u_lane_y (.clk_i, .rst_ni, .start_i(k_start), .init_i(k_init),
    .meas_i(rely), .q_i(q_q), .r_i(r_q), .est_o(est_y), .ctl_o(ctl_y));

  logic vstart_any;
  assign vstart_any = (state_q == StVelStart);
  tako_vel_div u_vel_x (.clk_i, .rst_ni, .start_i(vstart_any),
    .delta_i((ValueWidth+1)'(est_x) - (ValueWidth+1)'(old_x_q)), .neg_i(1'b1),
    .dt_i(dt_q == '0 ? TimeWidth'(1) : dt_q), .vel_o(vx), .done_o(vdx));
  tako_vel_div u_vel_y (.clk_i, .rst_ni, .start_i(vstart_any),
    .delta_i((ValueWidth+1)'(est_y) - (ValueWidth+1)'(old_y_q)), .neg_i(1'b1),
    .dt_i(dt_q == '0 ? TimeWidth'(1) : dt_q), .vel_o(vy), .done_o(vdy));
  tako_vel_div u_vel_z (.clk_i, .rst_ni, .start_i(vstart_any),
    .delta_i((ValueWidth+1)'(alt_q) - (ValueWidth+1)'(alt_old_q)), .neg_i(1'b0),
    .dt_i(dt_q == '0 ? TimeWidth'(1) : dt_q), .vel_o(vz), .done_o(vdz));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdx |-> vdy && vdz) else $error("velocity lanes out of step");
  kal_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_x.done |-> ctl_y.done) else $error("Kalman lanes out of step");
  no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("input taken with result pending");
  vstart_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_start |-> state_q == StVelStart) else $error("velocity start out of sequence");
endmodule

[dv/tb_two_axis_scalar_kalman_odometry.sv]
// Testbench for two_axis_scalar_kalman_odometry: directed and random samples,
// checked against an in-bench fixed-point predictor of the Kalman and velocity lanes.
// Depends on tako_pkg and the top-level RTL only.
module tb_two_axis_scalar_kalman_odometry;
  import tako_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned SettleCycles = 120;
  localparam longint VMax = 64'sd2147483647;
  localparam longint VMin = -64'sd2147483648;
  localparam longint unsigned VarMax = 64'hFFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  two_axis_scalar_kalman_odometry u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  longint unsigned q_noise, r_noise;
  bit              have_origin;
  longint          org_x, org_y, kf_x, kf_y, last_alt;
  longint unsigned kf_var_x, kf_var_y;
  logic [47:0]     last_time;

  out_item_t expected_odom[$];
  out_item_t got;
  int unsigned mismatches;
  int unsigned stall_cycles;
  bit calm;

  // random walk for well-formed tracks
  longint walk_x, walk_y, walk_z;
  logic [47:0] walk_t;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_q16(longint v);
    return v > VMax ? VMax : (v < VMin ? VMin : v);
  endfunction

  function automatic longint unsigned frac_mul(longint unsigned m, longint unsigned g);
    return (m >> 16) * g + (((m & 64'hFFFF) * g) >> 16);
  endfunction

  task automatic axis_filter_step(inout longint est, inout longint unsigned var_p,
                                  input longint meas);
    longint unsigned p, den, gain, mag;
    longint innov;
    p = var_p + q_noise;
    if (p > VarMax) p = VarMax;
    den = p + r_noise;
    gain = (den != 0) ? (p << 16) / den : 0;
    innov = meas - est;
    mag = innov < 0 ? -innov : innov;
    mag = frac_mul(mag, gain);
    est = clamp_q16(est + (innov < 0 ? -longint'(mag) : longint'(mag)));
    var_p = frac_mul(p, 64'd65536 - gain);
  endtask

  function automatic longint velocity_q16(longint delta, longint unsigned dt, bit flip);
    bit neg;
    longint unsigned m, lim, tot;
    neg = (delta < 0) ^ flip;
    m = delta < 0 ? -delta : delta;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    tot = m * 64'd1000000 / dt;
    if (tot > lim) tot = lim;
    return neg ? -longint'(tot) : longint'(tot);
  endfunction

  task automatic predict_odometry(in_item_t it);
    logic [47:0] dt;
    longint old_x, old_y, old_alt, alt;
    out_item_t r;
    dt = it.time_us - last_time;
    old_x = kf_x;
    old_y = kf_y;
    old_alt = last_alt;
    alt = longint'(it.altitude);
    last_time = it.time_us;
    last_alt = alt;
    if (!have_origin) begin
      have_origin = 1'b1;
      org_x = longint'(it.meas_x);
      org_y = longint'(it.meas_y);
      kf_x = 0;
      kf_y = 0;
      kf_var_x = 0;
      kf_var_y = 0;
    end else begin
      axis_filter_step(kf_y, kf_var_y, clamp_q16(longint'(it.meas_y) - org_y));
      axis_filter_step(kf_x, kf_var_x, clamp_q16(longint'(it.meas_x) - org_x));
      r.filtered_x = kf_x[31:0];
      r.filtered_y = kf_y[31:0];
      r.altitude_out = alt[31:0];
      r.dt_zero = (dt == 0);
      r.vel_x = '0;
      r.vel_y = '0;
      r.vel_z = '0;
      if (dt != 0) begin
        r.vel_x = 32'(velocity_q16(kf_x - old_x, 64'(dt), 1'b1));
        r.vel_y = 32'(velocity_q16(kf_y - old_y, 64'(dt), 1'b1));
        r.vel_z = 32'(velocity_q16(alt - old_alt, 64'(dt), 1'b0));
      end
      expected_odom.push_back(r);
    end
  endtask

  task automatic send_sample(in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_odometry(it);
  endtask

  task automatic send_xyzt(longint x, longint y, longint z, logic [47:0] t);
    in_item_t it;
    it.meas_x = x[31:0];
    it.meas_y = y[31:0];
    it.altitude = z[31:0];
    it.time_us = t;
    send_sample(it);
  endtask

  // block is idle: no result pending and the origin item has had time to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_odom.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_addr_e addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegProcessNoise) q_noise = data;
    else r_noise = data;
  endtask

  task automatic set_noise(logic [31:0] q, logic [31:0] r);
    settle();
    apb_write(RegProcessNoise, q);
    apb_write(RegMeasurementNoise, r);
  endtask

  task automatic test_origin_and_extremes();
    send_xyzt(0, 0, 0, 48'd1000);
    send_xyzt(VMax, VMin, VMax, 48'd1001);
    send_xyzt(VMin, VMax, VMin, 48'd1002);
    send_xyzt(VMax, VMax, 0, 48'd1002);
    send_xyzt(-65536, 65536, 32768, 48'd500);
    send_xyzt(12345, -54321, -1, 48'hFFFF_FFFF_FFFF);
    send_xyzt(0, 0, 65536, 48'd0);
    send_xyzt(VMin, VMin, VMin, 48'd20000);
    send_xyzt(VMax, VMax, VMax, 48'h8000_0000_0000);
    send_xyzt(1, -1, 1, 48'h8000_0000_0001);
  endtask

  task automatic test_noise_extremes();
    set_noise(32'd0, 32'd0);
    send_xyzt(100000, -100000, 5, 48'd2000);
    send_xyzt(100000, -100000, 5, 48'd2000);
    set_noise(32'hFFFF_FFFF, 32'd0);
    send_xyzt(VMax, VMin, 7, 48'd3000);
    send_xyzt(-300000, 300000, 7, 48'd3001);
    set_noise(32'd0, 32'hFFFF_FFFF);
    send_xyzt(VMin, VMax, 9, 48'd4000);
    set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_xyzt(VMax, VMin, 11, 48'd5000);
    send_xyzt(0, 0, 11, 48'd5100);
  endtask

  task automatic random_samples(int unsigned n);
    in_item_t it;
    int unsigned k;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      walk_x += longint'($urandom_range(0, 400000)) - 200000;
      walk_y += longint'($urandom_range(0, 400000)) - 200000;
      walk_z += longint'($urandom_range(0, 40000)) - 20000;
      walk_x = clamp_q16(walk_x);
      walk_y = clamp_q16(walk_y);
      walk_z = clamp_q16(walk_z);
      if (k < 4) walk_t = walk_t;
      else if (k < 7) walk_t = {16'($urandom_range(0, 16'hFFFF)), $urandom()};
      else if (k < 10) walk_t = walk_t + 48'($urandom_range(1, 20));
      else walk_t = walk_t + 48'($urandom_range(1, 200000));
      if (k >= 90) begin
        it.meas_x = $urandom();
        it.meas_y = $urandom();
        it.altitude = $urandom();
      end else begin
        it.meas_x = 32'(walk_x + longint'($urandom_range(0, 2000)) - 1000);
        it.meas_y = 32'(walk_y + longint'($urandom_range(0, 2000)) - 1000);
        it.altitude = walk_z[31:0];
      end
      it.time_us = walk_t;
      send_sample(it);
    end
  endtask

  task automatic test_random_settings();
    set_noise(QReset, RReset);
    random_samples(300);
    set_noise(32'd0, 32'hFFFF_FFFF);
    random_samples(200);
    set_noise(32'hFFFF_FFFF, 32'd0);
    random_samples(200);
    set_noise($urandom_range(0, 32'h0004_0000), $urandom());
    random_samples(300);
    set_noise($urandom(), $urandom());
    random_samples(300);
  endtask

  task automatic test_drain_pause();
    settle();
    random_samples(20);
    in_valid_i <= 1'b0;
    while (expected_odom.size() != 0) @(posedge clk_i);
    random_samples(20);
  endtask

  task automatic test_no_idle();
    set_noise(32'd65536, 32'd131072);
    calm = 1'b1;
    random_samples(150);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_odom.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%t result with no sample pending", $realtime);
      end else begin
        got = expected_odom.pop_front();
        check_field("filtered_x", got.filtered_x, out_data_o.filtered_x);
        check_field("filtered_y", got.filtered_y, out_data_o.filtered_y);
        check_field("altitude_out", got.altitude_out, out_data_o.altitude_out);
        check_field("vel_x", got.vel_x, out_data_o.vel_x);
        check_field("vel_y", got.vel_y, out_data_o.vel_y);
        check_field("vel_z", got.vel_z, out_data_o.vel_z);
        check_field("dt_zero", 32'(got.dt_zero), 32'(out_data_o.dt_zero));
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    mismatches = 0;
    q_noise = QReset;
    r_noise = RReset;
    have_origin = 1'b0;
    org_x = 0; org_y = 0; kf_x = 0; kf_y = 0; last_alt = 0;
    kf_var_x = 0; kf_var_y = 0; last_time = '0;
    walk_x = 0; walk_y = 0; walk_z = 0; walk_t = 48'd10000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_origin_and_extremes();
    test_noise_extremes();
    test_random_settings();
    test_drain_pause();
    test_no_idle();
    settle();
    if (mismatches == 0 && expected_odom.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
